[hdl/idt_pkg.sv]
// Shared types and constants of the inversion distance transform.
// Used by idt_ctrl, idt_dp and inversion_distance_transform; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package idt_pkg;

	localparam int SYMBOL_BITS = 8;
	localparam int NSYM = 1 << SYMBOL_BITS;
	localparam int ADDR_W = 16;
	localparam int TOTAL_W = 20;
	localparam logic [ADDR_W-1:0] MAX_BLOCK = 16'd65535;
	localparam logic [7:0] SYM_LAST = 8'(NSYM - 1);
	localparam logic [15:0] NO_GAP = 16'hFFFF;

	// input command codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_PULL = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SYM_END,
		ST_EMIT
	} state_t;

	typedef enum logic {
		PH_LOAD,
		PH_EMIT
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic scan;
		logic sym_end;
		logic emit_step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic start_xform;
		logic pull_ok;
		logic scan_idle;
		logic last_sym;
	} dp_stat_t;

	// per-symbol record kept for the emit walk
	typedef struct packed {
		logic [15:0] count;
		logic [15:0] min_gap;
		logic [1:0] width;
	} sym_meta_t;

endpackage
`default_nettype wire

[hdl/inversion_distance_transform.sv]
// Top level of the inversion distance transform: controller plus datapath.
// Depends on idt_pkg, idt_ctrl and idt_dp.
//
// A command is taken when start is high and busy is low; every command gives
// one result on the output ports, marked by done for a single cycle, which the
// receiver must take then. A load or a rejected pull gives its result in the
// cycle after its transfer; a taken pull passes first through the emit step
// state, which registers its result. The load that carries block_end starts
// the transform, which holds busy high while the byte-store read port walks the
// shrinking block once per symbol, 256 passes in all, each pass followed by a
// close-out state. Stream bytes then come out one per pull, read from the
// registered outputs of the gap store and the symbol records.
`timescale 1ns / 1ps
`default_nettype none
module inversion_distance_transform (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic command,
	input wire logic [7:0] data_byte,
	input wire logic block_end,
	output logic done,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic out_last,
	output logic overflow
);

	idt_pkg::dp_cmd_t cmd;
	idt_pkg::dp_stat_t stat;

	idt_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.busy(busy),
		.cmd(cmd)
	);

	idt_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.command(command),
		.data_byte(data_byte),
		.block_end(block_end),
		.stat(stat),
		.done(done),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.out_last(out_last),
		.overflow(overflow)
	);

	// an emit step always yields a valid stream byte next cycle
	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_step |=> (done && out_valid))
		else $error("emit step gave no stream byte");

	// a stream byte only comes from an emit step
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> $past(cmd.emit_step))
		else $error("stream byte without emit step");

	// overflow and last belong to different result kinds
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((!overflow || !out_valid) && (!out_last || out_valid)))
		else $error("inconsistent result flags");

	// no two datapath commands (accept, scan, close-out, emit step) overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.accept, cmd.scan, cmd.sym_end, cmd.emit_step}))
		else $error("overlapping datapath commands");

endmodule
`default_nettype wire

[hdl/idt_ctrl.sv]
// Controller state machine of the inversion distance transform.
// Depends on idt_pkg; drives idt_dp through dp_cmd_t and reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none
module idt_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire idt_pkg::dp_stat_t stat,
	output logic busy,
	output idt_pkg::dp_cmd_t cmd
);

	idt_pkg::state_t state_q, state_d;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			idt_pkg::ST_IDLE: begin
				if (start && stat.start_xform) state_d = idt_pkg::ST_SCAN;
				else if (start && stat.pull_ok) state_d = idt_pkg::ST_EMIT;
			end
			idt_pkg::ST_SCAN: begin
				if (stat.scan_idle) state_d = idt_pkg::ST_SYM_END;
			end
			idt_pkg::ST_SYM_END: begin
				state_d = stat.last_sym ? idt_pkg::ST_IDLE : idt_pkg::ST_SCAN;
			end
			idt_pkg::ST_EMIT: begin
				state_d = idt_pkg::ST_IDLE;
			end
			default: state_d = idt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			idt_pkg::ST_IDLE: begin
				busy = 1'b0;
				cmd.accept = start;
			end
			idt_pkg::ST_SCAN: cmd.scan = 1'b1;
			idt_pkg::ST_SYM_END: cmd.sym_end = 1'b1;
			idt_pkg::ST_EMIT: cmd.emit_step = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

[hdl/idt_dp.sv]
// Datapath of the inversion distance transform: block store, gap store,
// symbol records, scan pipeline and emit walk. Depends on idt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module idt_dp (
	input wire logic clk,
	input wire logic arst_n,
	input wire idt_pkg::dp_cmd_t cmd,
	input wire logic command,
	input wire logic [7:0] data_byte,
	input wire logic block_end,
	output idt_pkg::dp_stat_t stat,
	output logic done,
	output logic [7:0] out_byte,
	output logic out_valid,
	output logic out_last,
	output logic overflow
);

	localparam int AW = idt_pkg::ADDR_W;

	// memories
	logic [7:0] byte_mem [2**AW];
	logic [15:0] gap_mem [2**AW];
	idt_pkg::sym_meta_t meta_mem [idt_pkg::NSYM];

	logic [7:0] byte_rd_s1;
	logic [15:0] gap_rd_q;
	idt_pkg::sym_meta_t meta_rd_q;

	// control registers
	idt_pkg::phase_t phase_q;
	logic [AW-1:0] fill_q, len_q, loc_q, w_q, cnt_q, prev_q, gptr_q, k_q;
	logic [15:0] min_q, max_q;
	logic [7:0] sym_q;
	logic [idt_pkg::TOTAL_W-1:0] total_q, ptr_q;
	logic [1:0] part_q;
	logic gaps_q, hi_q;
	logic vld_s1;
	logic [AW-1:0] loc_s1;

	// result registers
	logic done_q, valid_q, last_q, ovf_q;
	logic [7:0] byte_q;

	// command decode
	logic is_load, is_pull, load_ok, full;
	assign is_load = cmd.accept && (command == idt_pkg::CMD_LOAD);
	assign is_pull = cmd.accept && (command == idt_pkg::CMD_PULL);
	assign full = (fill_q >= idt_pkg::MAX_BLOCK);
	assign load_ok = is_load && (phase_q == idt_pkg::PH_LOAD) && !full;

	assign stat.start_xform = (command == idt_pkg::CMD_LOAD)
		&& (phase_q == idt_pkg::PH_LOAD) && block_end;
	assign stat.pull_ok = (command == idt_pkg::CMD_PULL) && (phase_q == idt_pkg::PH_EMIT);
	assign stat.scan_idle = (loc_q == len_q) && !vld_s1;
	assign stat.last_sym = (sym_q == idt_pkg::SYM_LAST);

	// scan: issue and match
	logic issue, match;
	logic [AW-1:0] gap_val;
	assign issue = cmd.scan && (loc_q != len_q);
	assign match = vld_s1 && (byte_rd_s1 == sym_q);
	assign gap_val = (cnt_q == '0) ? loc_s1 : AW'(loc_s1 - prev_q - 1'b1);

	// symbol close-out
	logic [15:0] max_red;
	logic [1:0] wid;
	logic [idt_pkg::TOTAL_W-1:0] glen;
	assign max_red = max_q - min_q;
	always_comb begin
		if (cnt_q == '0) wid = 2'd0;
		else if (max_red[15:8] != 8'd0) wid = 2'd2;
		else if (max_red[7:0] != 8'd0) wid = 2'd1;
		else wid = 2'd0;
		case (wid)
			2'd2: glen = {{(idt_pkg::TOTAL_W-AW-1){1'b0}}, cnt_q, 1'b0};
			2'd1: glen = {{(idt_pkg::TOTAL_W-AW){1'b0}}, cnt_q};
			default: glen = '0;
		endcase
		if (stat.last_sym) glen = '0;
	end

	// emit: byte select
	logic [15:0] red_gap;
	logic [7:0] emit_byte;
	logic stream_end;
	assign red_gap = gap_rd_q - meta_rd_q.min_gap;
	assign stream_end = (ptr_q + 1'b1) == total_q;
	always_comb begin
		if (gaps_q) begin
			emit_byte = hi_q ? red_gap[15:8] : red_gap[7:0];
		end else begin
			case (part_q)
				2'd0: emit_byte = meta_rd_q.count[7:0];
				2'd1: emit_byte = meta_rd_q.count[15:8];
				2'd2: emit_byte = meta_rd_q.min_gap[7:0];
				default: emit_byte = meta_rd_q.min_gap[15:8];
			endcase
		end
	end

	// byte store: load write, compaction write, scan read
	always_ff @(posedge clk) begin
		if (load_ok) byte_mem[fill_q] <= data_byte;
		else if (vld_s1 && !match) byte_mem[w_q] <= byte_rd_s1;
		byte_rd_s1 <= byte_mem[loc_q];
	end

	// gap store and symbol records
	always_ff @(posedge clk) begin
		if (match) gap_mem[AW'(gptr_q + cnt_q)] <= gap_val;
		gap_rd_q <= gap_mem[gptr_q];
		if (cmd.sym_end)
			meta_mem[sym_q] <= '{count: cnt_q,
				min_gap: (cnt_q == '0) ? idt_pkg::NO_GAP : min_q, width: wid};
		meta_rd_q <= meta_mem[sym_q];
	end

	// control and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= idt_pkg::PH_LOAD;
			fill_q <= '0; len_q <= '0; loc_q <= '0; w_q <= '0;
			cnt_q <= '0; prev_q <= '0; gptr_q <= '0; k_q <= '0;
			min_q <= idt_pkg::NO_GAP; max_q <= '0; sym_q <= '0;
			total_q <= '0; ptr_q <= '0; part_q <= '0;
			gaps_q <= 1'b0; hi_q <= 1'b0; vld_s1 <= 1'b0; loc_s1 <= '0;
			done_q <= 1'b0; valid_q <= 1'b0; last_q <= 1'b0; ovf_q <= 1'b0;
			byte_q <= '0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= issue;
			loc_s1 <= loc_q;

			// load transfer and rejected pulls
			if (is_load || (is_pull && !stat.pull_ok)) begin
				done_q <= 1'b1;
				valid_q <= 1'b0;
				last_q <= 1'b0;
				byte_q <= '0;
				ovf_q <= is_load && (phase_q == idt_pkg::PH_LOAD) && full;
			end
			if (load_ok) fill_q <= fill_q + 1'b1;
			if (is_load && stat.start_xform) begin
				len_q <= full ? fill_q : AW'(fill_q + 1'b1);
				loc_q <= '0; w_q <= '0; cnt_q <= '0; gptr_q <= '0;
				sym_q <= '0; total_q <= '0;
				min_q <= idt_pkg::NO_GAP; max_q <= '0;
			end

			// scan: advance and record
			if (issue) loc_q <= loc_q + 1'b1;
			if (match) begin
				cnt_q <= cnt_q + 1'b1;
				prev_q <= loc_s1;
				if (gap_val < min_q) min_q <= gap_val;
				if (gap_val > max_q) max_q <= gap_val;
			end else if (vld_s1) begin
				w_q <= w_q + 1'b1;
			end

			// close out one symbol
			if (cmd.sym_end) begin
				total_q <= total_q + glen + idt_pkg::TOTAL_W'(4);
				len_q <= w_q;
				loc_q <= '0; w_q <= '0; cnt_q <= '0;
				min_q <= idt_pkg::NO_GAP; max_q <= '0;
				if (stat.last_sym) begin
					phase_q <= idt_pkg::PH_EMIT;
					sym_q <= '0; gptr_q <= '0; ptr_q <= '0;
					part_q <= '0; gaps_q <= 1'b0; hi_q <= 1'b0; k_q <= '0;
				end else begin
					sym_q <= sym_q + 1'b1;
					gptr_q <= gptr_q + cnt_q;
				end
			end

			// emit one stream byte and advance the walk
			if (cmd.emit_step) begin
				done_q <= 1'b1;
				valid_q <= 1'b1;
				ovf_q <= 1'b0;
				byte_q <= emit_byte;
				last_q <= stream_end;
				ptr_q <= ptr_q + 1'b1;
				if (gaps_q) begin
					if ((meta_rd_q.width == 2'd2) && !hi_q) begin
						hi_q <= 1'b1;
					end else begin
						hi_q <= 1'b0;
						gptr_q <= gptr_q + 1'b1;
						if (k_q == AW'(meta_rd_q.count - 1'b1)) begin
							k_q <= '0;
							gaps_q <= 1'b0;
							sym_q <= sym_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end else if (part_q != 2'd3) begin
					part_q <= part_q + 1'b1;
				end else begin
					part_q <= '0;
					if (!stat.last_sym && (meta_rd_q.width != 2'd0)) begin
						gaps_q <= 1'b1;
					end else begin
						gptr_q <= gptr_q + meta_rd_q.count;
						sym_q <= sym_q + 1'b1;
					end
				end
				if (stream_end) begin
					phase_q <= idt_pkg::PH_LOAD;
					fill_q <= '0; sym_q <= '0; gptr_q <= '0; ptr_q <= '0;
					total_q <= '0; part_q <= '0; gaps_q <= 1'b0;
					hi_q <= 1'b0; k_q <= '0;
				end
			end
		end
	end

	assign done = done_q;
	assign out_byte = byte_q;
	assign out_valid = valid_q;
	assign out_last = last_q;
	assign overflow = ovf_q;

endmodule
`default_nettype wire
